// File: design/wbps_pkg.sv
// Shared constants, command codes and the per-step control struct
// for the wildcard byte pattern scanner. No dependencies.
package wbps_pkg;

	localparam int MAX_PATTERN_DFLT = 64;

	localparam int LEN_W    = 7;
	localparam int VALUE_W  = 8;
	localparam int INDEX_W  = 6;
	localparam int OFFSET_W = 32;

	// pattern byte that matches any region byte
	localparam logic [VALUE_W-1:0] WILDCARD = 8'h2A;

	// saturation value of the region byte counter
	localparam logic [OFFSET_W-1:0] CNT_MAX = '1;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_SCAN = 1'b1
	} cmd_t;

	// control of one scan byte after the cell compare stage
	typedef struct packed {
		logic                vld;
		logic                last;
		logic [OFFSET_W-1:0] cnt;
	} step_t;

endpackage

// File: design/wbps_if.sv
// Request and result channel interfaces of the pattern scanner.
// Depends on wbps_pkg for field widths.
interface wbps_req_if;
	logic                           valid;
	logic                           ready;
	logic                           command;
	logic [wbps_pkg::VALUE_W-1:0]   value;
	logic [wbps_pkg::INDEX_W-1:0]   index;
	logic                           last;

	modport source (output valid, command, value, index, last, input ready);
	modport sink   (input valid, command, value, index, last, output ready);
endinterface

interface wbps_res_if;
	logic                           valid;
	logic                           ready;
	logic                           found;
	logic [wbps_pkg::OFFSET_W-1:0]  offset;

	modport source (output valid, found, offset, input ready);
	modport sink   (input valid, found, offset, output ready);
endinterface

// File: design/wbps_cell.sv
// One scanner cell: a pattern byte of the rotating pattern ring, a byte of
// the region window shift line and its registered compare. Uses wbps_pkg.
module wbps_cell (
	input  logic                           clk,
	input  logic                           load_en,
	input  logic [wbps_pkg::VALUE_W-1:0]   load_val,
	input  logic                           rot_en,
	input  logic [wbps_pkg::VALUE_W-1:0]   pat_prev,
	input  logic                           shift_en,
	input  logic [wbps_pkg::VALUE_W-1:0]   win_in,
	input  logic                           step_en,
	output logic [wbps_pkg::VALUE_W-1:0]   pat,
	output logic [wbps_pkg::VALUE_W-1:0]   win,
	output logic                           eq
);

	logic [wbps_pkg::VALUE_W-1:0] pat_q;
	logic [wbps_pkg::VALUE_W-1:0] win_q;
	logic                         eq_s1;

	// write a loaded byte, or take the neighbor's byte while the ring rotates
	always_ff @(posedge clk) begin
		if (load_en) begin
			pat_q <= load_val;
		end else if (rot_en) begin
			pat_q <= pat_prev;
		end
	end

	// advance the window one byte per scanned request
	always_ff @(posedge clk) begin
		if (shift_en) begin
			win_q <= win_in;
		end
	end

	// compare against the byte this cell holds after the shift
	always_ff @(posedge clk) begin
		if (step_en) begin
			eq_s1 <= (pat_q == wbps_pkg::WILDCARD) || (win_in == pat_q);
		end
	end

	assign pat = pat_q;
	assign win = win_q;
	assign eq  = eq_s1;

endmodule

// File: design/wbps_verdict.sv
// Match decision: registered AND tree over the cell compares, first-match
// tracking per region and the result output register. Uses wbps_pkg.
module wbps_verdict #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DFLT,
	parameter int IW          = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
	parameter int NW          = $clog2(MAX_PATTERN + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wbps_pkg::step_t                step_s1,
	input  logic [MAX_PATTERN-1:0]         eq_s1,
	input  logic [IW-1:0]                  first_cell,
	input  logic [NW-1:0]                  n_eff,
	input  logic                           res_ready,
	output logic                           res_valid,
	output logic                           res_found,
	output logic [wbps_pkg::OFFSET_W-1:0]  res_offset,
	output logic                           adv
);

	localparam int GRP  = 8;
	localparam int NGRP = (MAX_PATTERN + GRP - 1) / GRP;

	logic [NGRP-1:0]               grp_c;
	logic [NGRP-1:0]               grp_s2;
	logic                          vld_s2;
	logic                          last_s2;
	logic                          ok_s2;
	logic [wbps_pkg::OFFSET_W-1:0] off_s2;
	logic                          done_q;
	logic                          done_d;
	logic                          out_vld_q;
	logic                          found_q;
	logic [wbps_pkg::OFFSET_W-1:0] offset_q;
	logic                          hit;
	logic                          produce;
	logic                          fnd;

	// advance the whole pipe unless a result waits to be taken
	assign adv = !out_vld_q || res_ready;

	// reduce each group of eight cells; cells ahead of the pattern pass
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_c[g] = 1'b1;
			for (int i = 0; i < GRP; i++) begin
				if (g * GRP + i < MAX_PATTERN) begin
					if (32'(g * GRP + i) >= 32'(first_cell)) begin
						grp_c[g] = grp_c[g] & eq_s1[g * GRP + i];
					end
				end
			end
		end
	end

	// register group results, length check and start offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2  <= step_s1.vld;
			last_s2 <= step_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			grp_s2 <= grp_c;
			ok_s2  <= step_s1.cnt >= wbps_pkg::OFFSET_W'(n_eff);
			off_s2 <= step_s1.cnt - wbps_pkg::OFFSET_W'(n_eff);
		end
	end

	assign hit = ok_s2 && (&grp_s2);

	// report the first match, drop bytes after it, report a miss at region end
	always_comb begin
		produce = 1'b0;
		fnd     = 1'b0;
		done_d  = done_q;
		if (vld_s2) begin
			priority if (done_q) begin
				if (last_s2) begin
					done_d = 1'b0;
				end
			end else if (hit) begin
				produce = 1'b1;
				fnd     = 1'b1;
				done_d  = !last_s2;
			end else if (last_s2) begin
				produce = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			done_q    <= done_d;
			out_vld_q <= produce;
		end
	end

	// hold the result payload until taken
	always_ff @(posedge clk) begin
		if (adv && produce) begin
			found_q  <= fnd;
			offset_q <= fnd ? off_s2 : '0;
		end
	end

	assign res_valid  = out_vld_q;
	assign res_found  = found_q;
	assign res_offset = offset_q;

	a_miss_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !found_q |-> offset_q == '0)
		else $error("not-found result with nonzero offset");

	a_squash_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s2 && done_q |=> !out_vld_q)
		else $error("result given after a match in the same region");

	a_region_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s2 && last_s2 |=> !done_q)
		else $error("match flag kept past region end");

endmodule

// File: design/wildcard_byte_pattern_scanner.sv
// Top level of the wildcard byte pattern scanner: row of wbps_cell, the
// pattern ring alignment, region byte counter and wbps_verdict.
// Depends on wbps_pkg, wbps_if (wbps_req_if, wbps_res_if).
//
//  channel  dir  handshake          payload
//  req      in   valid/ready        command, value[7:0], index[5:0], last
//  res      out  valid/ready        found, offset[31:0]
//  cfg      in   cfg_we (no wait)   cfg_wdata[6:0] = pattern_length
//
// One request per cycle unless stalled. A scan byte's result passes the cell
// compare, group AND and result registers before it leaves the output.
// A held result stalls the whole pipe and drops req.ready.
// A pattern_length write rotates the pattern ring into place one cell per
// cycle: req.ready stays low until the ring lines up with the new length.
// Reset needs no clearing pass; pattern bytes are undefined until loaded.
module wildcard_byte_pattern_scanner #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DFLT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wbps_pkg::LEN_W-1:0]   cfg_wdata,
	wbps_req_if.sink                     req,
	wbps_res_if.source                   res
);

	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int NW = $clog2(MAX_PATTERN + 1);
	localparam logic [IW-1:0] ROT_LAST = IW'(MAX_PATTERN - 1);

	logic [wbps_pkg::LEN_W-1:0]    len_q;
	logic [NW-1:0]                 n_eff;
	logic [IW-1:0]                 first_cell;
	logic [IW-1:0]                 rot_q;
	logic                          rot_busy;
	logic                          adv;
	logic                          acc;
	logic                          scan_acc;
	logic                          load_acc;
	logic                          load_ok;
	logic [31:0]                   load_sum;
	logic [31:0]                   load_tgt;
	logic [wbps_pkg::OFFSET_W-1:0] cnt_q;
	logic [wbps_pkg::OFFSET_W-1:0] cnt_inc;
	wbps_pkg::step_t               step_s1;
	logic [wbps_pkg::VALUE_W-1:0]  pat [MAX_PATTERN];
	logic [wbps_pkg::VALUE_W-1:0]  win [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]        eq;

	// hold the pattern length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= wbps_pkg::LEN_W'(1);
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	// clamp the length to 1..MAX_PATTERN
	always_comb begin
		priority if (len_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(len_q) > 32'(MAX_PATTERN)) begin
			n_eff = NW'(MAX_PATTERN);
		end else begin
			n_eff = NW'(len_q);
		end
	end

	// the pattern ends at the newest window cell: its first byte sits here
	assign first_cell = IW'(32'(MAX_PATTERN) - 32'(n_eff));

	// rotate the pattern ring until it lines up with the length
	assign rot_busy = rot_q != first_cell;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= ROT_LAST;
		end else if (rot_busy) begin
			rot_q <= (rot_q == ROT_LAST) ? '0 : rot_q + IW'(1);
		end
	end

	// request handshake
	assign req.ready = !rot_busy && adv;
	assign acc       = req.valid && req.ready;
	assign scan_acc  = acc && (req.command == wbps_pkg::CMD_SCAN);
	assign load_acc  = acc && (req.command == wbps_pkg::CMD_LOAD);

	// map a load index onto its cell in the rotated ring
	assign load_ok  = 32'(req.index) < 32'(MAX_PATTERN);
	assign load_sum = 32'(req.index) + 32'(rot_q);
	assign load_tgt = (load_sum >= 32'(MAX_PATTERN)) ? load_sum - 32'(MAX_PATTERN)
		: load_sum;

	// count region bytes, saturating; restart at region end
	assign cnt_inc = (cnt_q == wbps_pkg::CNT_MAX) ? cnt_q
		: cnt_q + wbps_pkg::OFFSET_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (scan_acc) begin
			cnt_q <= req.last ? '0 : cnt_inc;
		end
	end

	// carry the byte's control alongside the cell compares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= '0;
		end else if (adv) begin
			step_s1.vld  <= scan_acc;
			step_s1.last <= req.last;
			step_s1.cnt  <= cnt_inc;
		end
	end

	// row of cells: newest region byte enters the top cell
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		logic [wbps_pkg::VALUE_W-1:0] win_in;

		if (j == MAX_PATTERN - 1) begin : g_top
			assign win_in = req.value;
		end else begin : g_mid
			assign win_in = win[j + 1];
		end

		wbps_cell u_cell (
			.clk      (clk),
			.load_en  (load_acc && load_ok && (load_tgt == 32'(j))),
			.load_val (req.value),
			.rot_en   (rot_busy),
			.pat_prev (pat[(j + MAX_PATTERN - 1) % MAX_PATTERN]),
			.shift_en (scan_acc),
			.win_in   (win_in),
			.step_en  (adv),
			.pat      (pat[j]),
			.win      (win[j]),
			.eq       (eq[j])
		);
	end

	wbps_verdict #(
		.MAX_PATTERN (MAX_PATTERN),
		.IW          (IW),
		.NW          (NW)
	) u_verdict (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_s1    (step_s1),
		.eq_s1      (eq),
		.first_cell (first_cell),
		.n_eff      (n_eff),
		.res_ready  (res.ready),
		.res_valid  (res.valid),
		.res_found  (res.found),
		.res_offset (res.offset),
		.adv        (adv)
	);

	a_region_restart: assert property (@(posedge clk) disable iff (!arst_n)
		scan_acc && req.last |=> cnt_q == '0)
		else $error("byte counter not restarted after region end");

endmodule

// File: sim/tb_wildcard_byte_pattern_scanner.sv
// Self-checking testbench for wildcard_byte_pattern_scanner: directed and random requests,
// with a scoreboard class that predicts each found/not-found verdict.
// Depends on wbps_pkg, wbps_if and the scanner RTL.
`timescale 1ns / 100ps

module tb_wildcard_byte_pattern_scanner;
	import wbps_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned SETTLE      = 10;

	// Predicts scanner verdicts and checks them in order.
	class match_tracker;
		typedef struct {
			logic                found;
			logic [OFFSET_W-1:0] offset;
		} verdict_t;

		bit [VALUE_W-1:0]  pat    [MAX_PATTERN_DFLT];
		bit [VALUE_W-1:0]  window [MAX_PATTERN_DFLT];
		bit [OFFSET_W-1:0] seen;
		bit                done;
		bit [LEN_W-1:0]    len = 1;
		verdict_t          verdicts[$];
		int unsigned       errors;
		int unsigned       answered;

		function int unsigned span();
			if (len == 0) return 1;
			if (len > MAX_PATTERN_DFLT) return MAX_PATTERN_DFLT;
			return len;
		endfunction

		function void set_length(bit [LEN_W-1:0] v);
			len = v;
		endfunction

		function void clear_region();
			foreach (window[k]) window[k] = '0;
			seen = '0;
			done = 1'b0;
		endfunction

		function void note_request(cmd_t cmd, bit [VALUE_W-1:0] val, bit [INDEX_W-1:0] idx,
				bit tail);
			int unsigned n;
			int unsigned k;
			bit hit;
			verdict_t v;
			if (cmd == CMD_LOAD) begin
				pat[idx] = val;
				return;
			end
			// bytes after a match are dropped until the region ends
			if (done) begin
				if (tail) clear_region();
				return;
			end
			for (k = 0; k < MAX_PATTERN_DFLT - 1; k++) window[k] = window[k + 1];
			window[MAX_PATTERN_DFLT - 1] = val;
			if (seen != CNT_MAX) seen++;
			n = span();
			hit = (seen >= n);
			for (k = 0; k < n; k++)
				if (pat[k] != WILDCARD && window[MAX_PATTERN_DFLT - n + k] != pat[k]) hit = 1'b0;
			if (hit) begin
				v.found = 1'b1;
				v.offset = seen - n;
				verdicts.push_back(v);
				if (tail) clear_region();
				else done = 1'b1;
			end else if (tail) begin
				v.found = 1'b0;
				v.offset = '0;
				verdicts.push_back(v);
				clear_region();
			end
		endfunction

		function void check_verdict(logic found, logic [OFFSET_W-1:0] offset);
			verdict_t want;
			answered++;
			if (verdicts.size() == 0) begin
				$error("unexpected result: found=%0b offset=%0d", found, offset);
				errors++;
				return;
			end
			want = verdicts.pop_front();
			if (found !== want.found) begin
				$error("found: expected %0b, got %0b", want.found, found);
				errors++;
			end
			if (offset !== want.offset) begin
				$error("offset: expected %0d, got %0d", want.offset, offset);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [LEN_W-1:0] cfg_wdata;

	wbps_req_if req_ch();
	wbps_res_if res_ch();

	match_tracker board = new();
	bit          steady;
	int unsigned sent;

	wildcard_byte_pattern_scanner uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.res       (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// mostly no pause, some short ones, a few long ones
	function automatic int unsigned pause_len();
		int unsigned r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one request, hold it until taken, then maybe idle.
	task automatic send_req(cmd_t cmd, bit [VALUE_W-1:0] val, bit [INDEX_W-1:0] idx, bit tail);
		int unsigned gap;
		req_ch.valid   <= 1'b1;
		req_ch.command <= cmd;
		req_ch.value   <= val;
		req_ch.index   <= idx;
		req_ch.last    <= tail;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		board.note_request(cmd, val, idx, tail);
		sent++;
		gap = pause_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every verdict is back and the pipe is quiet.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (board.verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_length(bit [LEN_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_length(v);
	endtask

	// Stream one region, often with the pattern planted somewhere in it.
	task automatic scan_region(int unsigned len);
		bit [VALUE_W-1:0] stream[$];
		int unsigned n;
		int unsigned start;
		int unsigned k;
		int unsigned mode;
		n = board.span();
		for (k = 0; k < len; k++) stream.push_back(8'($urandom_range(0, 255)));
		mode = $urandom_range(0, 3);
		if (mode != 0) begin
			// mode 1 ends the match on the region's last byte when it fits
			start = (mode == 1 && len >= n) ? len - n : $urandom_range(0, len - 1);
			for (k = 0; k < n && start + k < len; k++)
				if (board.pat[k] != WILDCARD) stream[start + k] = board.pat[k];
		end
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 24) == 0)
				send_req(CMD_LOAD, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
					1'($urandom_range(0, 1)));
			send_req(CMD_SCAN, stream[k], 6'($urandom_range(0, 63)), k == len - 1);
		end
	endtask

	// Accept verdicts with random stalls and one long hold-off.
	initial begin : result_sink
		int unsigned stall;
		int unsigned hold;
		bit held;
		stall = 0;
		hold = 0;
		held = 1'b0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) board.check_verdict(res_ch.found, res_ch.offset);
			if (!held && board.answered >= 50 && req_ch.valid) begin
				held = 1'b1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				stall = pause_len();
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		bit [LEN_W-1:0] lengths[12] = '{3, 0, 1, 64, 2, 127, 5, 65, 4, 8, 2, 16};
		int unsigned ph;
		int unsigned k;
		int unsigned n;
		int unsigned mark;
		int unsigned regions;
		int unsigned len;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		req_ch.valid   = 1'b0;
		req_ch.command = CMD_LOAD;
		req_ch.value   = '0;
		req_ch.index   = '0;
		req_ch.last    = 1'b0;
		steady         = 1'b0;
		sent           = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-byte pattern at the reset length; last is ignored on a load
		send_req(CMD_LOAD, 8'hFF, 6'd0, 1'b1);
		// match mid-region, then the remaining bytes are dropped
		send_req(CMD_SCAN, 8'h00, 6'd0, 1'b0);
		send_req(CMD_SCAN, 8'hFF, 6'd63, 1'b0);
		send_req(CMD_SCAN, 8'hFF, 6'd0, 1'b0);
		send_req(CMD_SCAN, 8'h2A, 6'd0, 1'b1);
		// one-byte regions: miss, then a match on the last byte
		send_req(CMD_SCAN, 8'h00, 6'd0, 1'b1);
		send_req(CMD_SCAN, 8'hFF, 6'd0, 1'b1);
		// wildcard matches anything, a literal 0x2A too
		send_req(CMD_LOAD, WILDCARD, 6'd0, 1'b0);
		send_req(CMD_SCAN, 8'h2A, 6'd0, 1'b1);
		send_req(CMD_SCAN, 8'h00, 6'd0, 1'b1);
		// two-byte pattern with a wildcard tail; top index loaded too
		write_length(7'd2);
		send_req(CMD_LOAD, 8'h00, 6'd0, 1'b0);
		send_req(CMD_LOAD, WILDCARD, 6'd1, 1'b0);
		send_req(CMD_LOAD, 8'h55, 6'd63, 1'b1);
		// region shorter than the pattern
		send_req(CMD_SCAN, 8'h00, 6'd0, 1'b1);
		send_req(CMD_SCAN, 8'hFF, 6'd0, 1'b0);
		send_req(CMD_SCAN, 8'h00, 6'd0, 1'b0);
		send_req(CMD_SCAN, 8'h2A, 6'd0, 1'b0);
		send_req(CMD_SCAN, 8'h11, 6'd0, 1'b1);
		// match would need the byte after the region's end
		send_req(CMD_SCAN, 8'hFF, 6'd0, 1'b0);
		send_req(CMD_SCAN, 8'h00, 6'd0, 1'b1);

		// random phases, one pattern length each
		for (ph = 0; ph < 12; ph++) begin
			steady = (ph % 4 == 2);
			write_length(lengths[ph]);
			n = board.span();
			for (k = 0; k < n; k++)
				send_req(CMD_LOAD,
					($urandom_range(0, 3) == 0) ? WILDCARD : 8'($urandom_range(0, 255)),
					6'(k), 1'($urandom_range(0, 1)));
			mark = sent;
			regions = 0;
			while (sent - mark < 40 || regions < 3) begin
				if (ph == 4 && regions == 2) drain();
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(n + 12, n + 80)
					: $urandom_range(1, n + 12);
				scan_region(len);
				regions++;
			end
		end

		drain();
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
